// ===== design/lrnv_pkg.sv =====
`default_nettype none
package lrnv_pkg;

	localparam int unsigned MaxLenDef   = 1024;
	localparam int unsigned FracBitsDef = 8;
	localparam int unsigned JobDepth    = 2;
	localparam int unsigned SampleW     = 16;
	localparam int unsigned PredW       = 32;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_TRUNC = 2'd1,
		STATUS_SAT   = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL,
		BK_NUM,
		BK_ABS,
		BK_DIV,
		BK_DONE
	} back_state_t;

	typedef struct packed {
		logic [PredW-1:0] prediction;
		status_t          status;
	} result_t;

endpackage
`default_nettype wire

// ===== design/linear_regression_next_value_top.sv =====
// Least-squares next-value predictor.
// Input queue side: sample (signed 16 bit) and last, taken when push is high
// and full is low. One sample per cycle is accumulated, up to MAX_LEN of them
// (count, sum y, sum x*y). The sample marked last closes the sequence: its
// totals go into a two-entry job queue and the accumulators clear in the
// same cycle, so the next sequence can start on the following cycle.
// Result queue side: prediction (Q.FRAC_BITS, 32 bit) and status are valid
// while empty is low and are taken when pop is high.
// Each job runs through a multiply, a numerator step, an absolute-value step
// and a restoring divider that retires one quotient bit per cycle; the
// divider sets the latency. The quotient is DW bits wide, DW =
// 2*clog2(MAX_LEN+1) + 20 + FRAC_BITS (50 with the defaults). A single-sample
// sequence skips the numerator, absolute-value and divider steps.
// Throughput: one item per cycle while the job queue has room; a new job is
// taken only after the previous result has been loaded into the output.
// If pop stays low, the finished result is held, the sequencer waits in its
// done state, the job queue fills and full then rises and stops all input.
// Reset clears the accumulators, both queues and the sequencer; empty is high.
`default_nettype none
module linear_regression_next_value_top #(
	parameter int unsigned MAX_LEN   = lrnv_pkg::MaxLenDef,
	parameter int unsigned FRAC_BITS = lrnv_pkg::FracBitsDef
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [lrnv_pkg::SampleW-1:0] sample,
	input  logic                                last,
	input  logic                                push,
	output logic                                full,
	output logic signed [lrnv_pkg::PredW-1:0]   prediction,
	output logic [1:0]                          status,
	output logic                                empty,
	input  logic                                pop
);
	import lrnv_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);
	localparam int unsigned SY_W  = SampleW + CNT_W;
	localparam int unsigned SXY_W = SampleW + 2 * CNT_W;
	localparam int unsigned JOB_W = 1 + CNT_W + SY_W + SXY_W;

	logic                    accept;
	logic                    job_push, job_pop, q_empty;
	logic [CNT_W-1:0]        f_n, b_n;
	logic signed [SY_W-1:0]  f_sy, b_sy;
	logic signed [SXY_W-1:0] f_sxy, b_sxy;
	logic                    f_tl, b_tl;
	logic [JOB_W-1:0]        q_din, q_dout;
	result_t                 res;

	assign accept = push && !full;

	lrnv_front #(
		.MAX_LEN(MAX_LEN),
		.CNT_W  (CNT_W),
		.SY_W   (SY_W),
		.SXY_W  (SXY_W)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.sample  (sample),
		.last    (last),
		.job_push(job_push),
		.job_n   (f_n),
		.job_sy  (f_sy),
		.job_sxy (f_sxy),
		.job_tl  (f_tl)
	);

	assign q_din = {f_tl, f_n, f_sy, f_sxy};

	lrnv_queue #(
		.WIDTH(JOB_W),
		.DEPTH(JobDepth)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (job_push),
		.din   (q_din),
		.full  (full),
		.empty (q_empty),
		.pop   (job_pop),
		.dout  (q_dout)
	);

	assign {b_tl, b_n, b_sy, b_sxy} = q_dout;

	lrnv_back #(
		.FRAC_BITS(FRAC_BITS),
		.CNT_W    (CNT_W),
		.SY_W     (SY_W),
		.SXY_W    (SXY_W)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(!q_empty),
		.job_n    (b_n),
		.job_sy   (b_sy),
		.job_sxy  (b_sxy),
		.job_tl   (b_tl),
		.job_pop  (job_pop),
		.pop      (pop),
		.empty    (empty),
		.res      (res)
	);

	assign prediction = res.prediction;
	assign status     = res.status;

endmodule
`default_nettype wire

// ===== design/lrnv_queue.sv =====
`default_nettype none
module lrnv_queue #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = lrnv_pkg::JobDepth
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	output logic             empty,
	input  logic             pop,
	output logic [WIDTH-1:0] dout
);
	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr, do_rd;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = push && !full;
	assign do_rd = pop && !empty;
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule
`default_nettype wire

// ===== design/lrnv_front.sv =====
`default_nettype none
module lrnv_front #(
	parameter int unsigned MAX_LEN = lrnv_pkg::MaxLenDef,
	parameter int unsigned CNT_W   = 11,
	parameter int unsigned SY_W    = 27,
	parameter int unsigned SXY_W   = 38
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                accept,
	input  logic signed [lrnv_pkg::SampleW-1:0] sample,
	input  logic                                last,
	output logic                                job_push,
	output logic [CNT_W-1:0]                    job_n,
	output logic signed [SY_W-1:0]              job_sy,
	output logic signed [SXY_W-1:0]             job_sxy,
	output logic                                job_tl
);
	import lrnv_pkg::*;

	logic [CNT_W-1:0]              cnt_q, cnt_nxt;
	logic signed [SY_W-1:0]        sy_q, sy_nxt;
	logic signed [SXY_W-1:0]       sxy_q, sxy_nxt;
	logic                          tl_q, tl_nxt;
	logic                          take;
	logic signed [CNT_W+SampleW:0] prod;

	assign take    = (cnt_q < CNT_W'(MAX_LEN));
	assign prod    = $signed({1'b0, cnt_q}) * sample;
	assign cnt_nxt = take ? cnt_q + 1'b1 : cnt_q;
	assign sy_nxt  = take ? sy_q + SY_W'(sample) : sy_q;
	assign sxy_nxt = take ? sxy_q + SXY_W'(prod) : sxy_q;
	assign tl_nxt  = tl_q | ~take;

	assign job_push = accept && last;
	assign job_n    = cnt_nxt;
	assign job_sy   = sy_nxt;
	assign job_sxy  = sxy_nxt;
	assign job_tl   = tl_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sy_q  <= '0;
			sxy_q <= '0;
			tl_q  <= 1'b0;
		end else if (accept) begin
			if (last) begin
				cnt_q <= '0;
				sy_q  <= '0;
				sxy_q <= '0;
				tl_q  <= 1'b0;
			end else begin
				cnt_q <= cnt_nxt;
				sy_q  <= sy_nxt;
				sxy_q <= sxy_nxt;
				tl_q  <= tl_nxt;
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/lrnv_back.sv =====
`default_nettype none
module lrnv_back #(
	parameter int unsigned FRAC_BITS = lrnv_pkg::FracBitsDef,
	parameter int unsigned CNT_W     = 11,
	parameter int unsigned SY_W      = 27,
	parameter int unsigned SXY_W     = 38
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    job_valid,
	input  logic [CNT_W-1:0]        job_n,
	input  logic signed [SY_W-1:0]  job_sy,
	input  logic signed [SXY_W-1:0] job_sxy,
	input  logic                    job_tl,
	output logic                    job_pop,
	input  logic                    pop,
	output logic                    empty,
	output lrnv_pkg::result_t       res
);
	import lrnv_pkg::*;

	localparam int unsigned NUM_W = SXY_W + 4;
	localparam int unsigned DEN_W = 2 * CNT_W;
	localparam int unsigned DW    = NUM_W + FRAC_BITS;
	localparam int unsigned IT_W  = $clog2(DW + 1);
	localparam int unsigned TOT_W = (DW + 1 > 33) ? DW + 1 : 33;

	back_state_t state_q, state_d;
	logic        out_load;
	logic        out_valid_q;
	result_t     out_q;

	logic [CNT_W-1:0]          n_q, nm1;
	logic signed [SY_W-1:0]    sy_q;
	logic signed [SXY_W-1:0]   sxy_q;
	logic                      tl_q;
	logic                      one_q;
	logic signed [CNT_W+SY_W:0] t_q;
	logic signed [NUM_W-1:0]   num_q;
	logic [DEN_W-1:0]          den_q;
	logic                      neg_q;
	logic [NUM_W-1:0]          mag;
	logic [DW-1:0]             div_q;
	logic [DEN_W-1:0]          rem_q;
	logic [IT_W-1:0]           it_q;
	logic [DEN_W:0]            trial;
	logic                      ge;
	logic                      rnd;
	logic [TOT_W-1:0]          total, limit;
	logic                      sat;
	logic [PredW-1:0]          pred;
	status_t                   stat;

	assign nm1   = n_q - 1'b1;
	assign mag   = num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);
	assign trial = {rem_q, div_q[DW-1]};
	assign ge    = (trial >= {1'b0, den_q});
	assign rnd   = ({rem_q, 1'b0} >= {1'b0, den_q});
	assign total = TOT_W'(div_q) + TOT_W'(rnd);
	assign limit = TOT_W'(32'h7FFF_FFFF) + TOT_W'(neg_q);

	always_comb begin
		sat  = 1'b0;
		pred = '0;
		if (one_q) begin
			pred = PredW'(sy_q) <<< FRAC_BITS;
		end else if (total > limit) begin
			sat  = 1'b1;
			pred = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else begin
			pred = neg_q ? -total[PredW-1:0] : total[PredW-1:0];
		end
		if (sat) begin
			stat = STATUS_SAT;
		end else if (tl_q) begin
			stat = STATUS_TRUNC;
		end else begin
			stat = STATUS_OK;
		end
	end

	always_comb begin
		state_d  = state_q;
		job_pop  = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (job_valid) begin
					job_pop = 1'b1;
					state_d = BK_MUL;
				end
			end
			BK_MUL: begin
				state_d = one_q ? BK_DONE : BK_NUM;
			end
			BK_NUM: begin
				state_d = BK_ABS;
			end
			BK_ABS: begin
				state_d = BK_DIV;
			end
			BK_DIV: begin
				if (it_q == IT_W'(1)) begin
					state_d = BK_DONE;
				end
			end
			BK_DONE: begin
				if (!out_valid_q || pop) begin
					out_load = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				n_q   <= job_n;
				sy_q  <= job_sy;
				sxy_q <= job_sxy;
				tl_q  <= job_tl;
				one_q <= (job_n == CNT_W'(1));
			end
			BK_MUL: begin
				t_q <= $signed({1'b0, nm1}) * sy_q;
			end
			BK_NUM: begin
				den_q <= DEN_W'(n_q) * DEN_W'(nm1);
				num_q <= (NUM_W'(sxy_q) <<< 2) + (NUM_W'(sxy_q) <<< 1) - (NUM_W'(t_q) <<< 1);
			end
			BK_ABS: begin
				neg_q <= num_q[NUM_W-1];
				div_q <= DW'(mag) << FRAC_BITS;
				rem_q <= '0;
				it_q  <= IT_W'(DW);
			end
			BK_DIV: begin
				rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
				div_q <= {div_q[DW-2:0], ge};
				it_q  <= it_q - 1'b1;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_q.prediction <= pred;
			out_q.status     <= stat;
		end
	end

	assign empty = !out_valid_q;
	assign res   = out_q;

endmodule
`default_nettype wire

// ===== design/lrnv_checker.sv =====
`default_nettype none
module lrnv_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              last,
	input logic                              push,
	input logic                              full,
	input logic signed [lrnv_pkg::PredW-1:0] prediction,
	input logic [1:0]                        status,
	input logic                              empty,
	input logic                              pop
);
	import lrnv_pkg::*;

	logic [2:0] pend_q;
	logic       seq_end, res_take;

	assign seq_end  = push && !full && last;
	assign res_take = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (seq_end && !res_take) begin
			pend_q <= pend_q + 1'b1;
		end else if (res_take && !seq_end) begin
			pend_q <= pend_q - 1'b1;
		end
	end

	a_res_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> pend_q != 3'd0)
		else $error("result shown with no sequence outstanding");

	a_sat_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == STATUS_SAT) |->
			(prediction == 32'h7FFF_FFFF || prediction == 32'h8000_0000))
		else $error("saturated status with unclamped prediction");

	a_res_held: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("result withdrawn before pop");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> ($stable(prediction) && $stable(status)))
		else $error("result changed while stalled");

endmodule

bind linear_regression_next_value_top lrnv_checker u_lrnv_checker (.*);
`default_nettype wire
